FILE: rtl/tcgp_pkg.sv
// Shared field widths and controller/datapath handshake types for the cell placement grid.
package tcgp_pkg;

  // Fixed field widths of the cell and result items
  localparam int ROW_W  = 6;
  localparam int SPAN_W = 7;
  localparam int COL_W  = 6;
  localparam int EXT_W  = 7;
  localparam int BIT_W  = 3;

  // Packed stream widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  // Highest bit of a span, first bit taken by the run-length search
  localparam logic [BIT_W-1:0] SPAN_TOP_BIT = 3'd6;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             accept;    // latch a new cell
    logic             rd_own;    // read the cell's own row
    logic             run_step;  // one bit of the run-length search
    logic [BIT_W-1:0] bit_sel;   // span bit for this step
    logic             pick;      // choose the first fitting column
    logic             mark;      // write the own row and pointer
    logic             rd_span;   // read the next covered row
    logic             wr_span;   // write the next covered row
    logic             out_load;  // move the result into the output register
  } tcgp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic found;      // a free run was found
    logic span_more;  // another covered row is still to be marked
    logic out_free;   // output register can take a result
  } tcgp_stat_t;

endpackage

FILE: rtl/table_cell_grid_placement.sv
// Top level of the table cell placement grid: controller plus datapath.
//
//  channel  direction  handshake              payload
//  s_*      in         s_tvalid / s_tready    s_tdata: row, col span, row span; s_tuser: clear
//  m_*      out        m_tvalid / m_tready    m_tdata: column, table width; m_tuser: overflow
//  cfg_*    in         cfg_valid / cfg_ready  cfg_data: table row count
//
// After the pick, a placed cell marks its own row, then each extra covered row by a
// read-modify-write of the row store; an overflowing cell goes straight to the hand-off.
// The run search walks the 7 column-span bits one per cycle.
// Reset is synchronous; it clears the row valid bits, width, row count and output.
// A result waiting on m_tready stalls only the final hand-off, not the next cell's work.
module table_cell_grid_placement import tcgp_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // row_index[5:0], col_span[12:6], row_span[19:13]
  input  logic                  s_tuser,   // clear_table[0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // column_index[5:0], table_columns[12:6]
  output logic                  m_tuser,   // overflow[0]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [EXT_W-1:0]      cfg_data   // table_rows
);

  tcgp_cmd_t  cmd;
  tcgp_stat_t stat;

  // Register writes must arrive only while idle; the block itself does not enforce it
  assign cfg_ready = 1'b1;

  tcgp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcgp_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data)
  );

endmodule

FILE: rtl/tcgp_datapath.sv
// Datapath: row store, run-length search, marking, table width and output register.
module tcgp_datapath import tcgp_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tcgp_cmd_t             cmd,
  output tcgp_stat_t            stat,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser,
  input  logic                  cfg_write,
  input  logic [EXT_W-1:0]      cfg_data
);

  // Rows reachable by own row plus span stay below 128
  localparam int ROWS = (MAX_ROWS < 128) ? MAX_ROWS : 128;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int WW   = EXT_W + MAX_COLS;

  localparam logic [10:0]         ROW_LAST  = 11'(MAX_ROWS - 1);
  localparam logic [10:0]         ROW_LIM   = 11'(MAX_ROWS);
  localparam logic [EXT_W-1:0]    COLS_FULL = EXT_W'(MAX_COLS);
  localparam logic [COL_W-1:0]    COL_LAST  = COL_W'(MAX_COLS - 1);
  localparam logic [MAX_COLS-1:0] ONES      = '1;
  localparam logic [MAX_COLS-1:0] ONE       = MAX_COLS'(1);

  // Index of the lowest set bit
  function automatic logic [COL_W-1:0] low_index(input logic [MAX_COLS-1:0] v);
    logic [MAX_COLS-1:0] lo;
    logic [COL_W-1:0]    idx;
    lo  = v & (~v + ONE);
    idx = '0;
    for (int i = 0; i < MAX_COLS; i++) begin
      if (lo[i]) idx = idx | COL_W'(i);
    end
    return idx;
  endfunction

  // Cell registers
  logic [6:0]          row_c;
  logic [SPAN_W-1:0]   cspan;
  logic [SPAN_W-1:0]   rspan;
  logic [MAX_COLS-1:0] lenmask;

  // Search and marking registers
  logic [MAX_COLS-1:0] g;
  logic [SPAN_W-1:0]   run_len;
  logic [COL_W-1:0]    col;
  logic                found;
  logic [MAX_COLS-1:0] mask;
  logic [7:0]          span_row;
  logic [SPAN_W-1:0]   span_left;
  logic [EXT_W-1:0]    extent;
  logic [EXT_W-1:0]    table_rows;

  // Row store: pointer in the top bits, occupancy below
  logic [WW-1:0]   mem [ROWS];
  logic [ROWS-1:0] row_valid;
  logic [WW-1:0]   rd_data;
  logic            rd_ok;

  // Input field unpack
  logic [ROW_W-1:0]  in_row;
  logic [SPAN_W-1:0] in_cspan;
  logic [SPAN_W-1:0] in_rspan;
  logic [SPAN_W-1:0] in_cspan_c;
  logic [SPAN_W-1:0] in_rspan_c;
  logic [6:0]        in_row_c;

  assign in_row     = s_tdata[5:0];
  assign in_cspan   = s_tdata[12:6];
  assign in_rspan   = s_tdata[19:13];
  assign in_cspan_c = (in_cspan == '0) ? SPAN_W'(1) : in_cspan;
  assign in_rspan_c = (in_rspan == '0) ? SPAN_W'(1) : in_rspan;
  assign in_row_c   = (11'(in_row) > ROW_LAST) ? ROW_LAST[6:0] : 7'(in_row);

  // Read word as seen through the valid bit
  logic [MAX_COLS-1:0] rd_occ;
  logic [EXT_W-1:0]    rd_ptr;
  assign rd_occ = rd_ok ? rd_data[MAX_COLS-1:0] : '0;
  assign rd_ptr = rd_ok ? rd_data[WW-1 -: EXT_W] : '0;

  // Search step and placement math
  logic                span_bit;
  logic [MAX_COLS-1:0] step_t;
  logic [MAX_COLS-1:0] cand;
  logic [MAX_COLS-1:0] mask_c;
  logic [EXT_W-1:0]    run_end;
  logic [AW-1:0]       raddr;
  logic [AW-1:0]       waddr;
  logic [WW-1:0]       wdata;
  logic                we;

  assign span_bit = cspan[cmd.bit_sel];
  assign step_t   = g & (g >> run_len);
  assign cand     = g & (ONES << rd_ptr);
  assign mask_c   = lenmask << col;
  assign run_end  = EXT_W'(col) + cspan;

  assign raddr = cmd.rd_own ? row_c[AW-1:0] : span_row[AW-1:0];
  assign waddr = cmd.mark ? row_c[AW-1:0] : span_row[AW-1:0];
  assign wdata = cmd.mark ? {run_end, rd_occ | mask_c} : {rd_ptr, rd_occ | mask};
  assign we    = cmd.mark | cmd.wr_span;

  // Status
  assign stat.found     = found;
  assign stat.span_more = (span_left != '0) && (span_row < {1'b0, table_rows}) &&
                          (11'(span_row) < ROW_LIM);
  assign stat.out_free  = !m_tvalid || m_tready;

  // Row store write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_own || cmd.rd_span) begin
      rd_data <= mem[raddr];
    end
  end

  // Valid bits: cleared by reset or a table clear, set on write
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_ok     <= 1'b0;
    end else begin
      if (cmd.accept && s_tuser) begin
        row_valid <= '0;
      end else if (we) begin
        row_valid[waddr] <= 1'b1;
      end
      if (cmd.rd_own || cmd.rd_span) begin
        rd_ok <= row_valid[raddr];
      end
    end
  end

  // Cell latch, search and marking
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      row_c   <= in_row_c;
      cspan   <= in_cspan_c;
      rspan   <= in_rspan_c;
      lenmask <= ~(ONES << in_cspan_c);
      run_len <= '0;
    end
    if (cmd.run_step) begin
      if (run_len == '0) begin
        if (span_bit) begin
          g       <= ~rd_occ;
          run_len <= SPAN_W'(1);
        end
      end else if (span_bit) begin
        g       <= step_t & (step_t >> 1);
        run_len <= {run_len[SPAN_W-2:0], 1'b1};
      end else begin
        g       <= step_t;
        run_len <= {run_len[SPAN_W-2:0], 1'b0};
      end
    end
    if (cmd.pick) begin
      col <= low_index(cand);
    end
    if (cmd.mark) begin
      mask      <= mask_c;
      span_row  <= 8'(row_c) + 8'd1;
      span_left <= rspan - SPAN_W'(1);
    end
    if (cmd.wr_span) begin
      span_row  <= span_row + 8'd1;
      span_left <= span_left - SPAN_W'(1);
    end
  end

  // Control-side registers: found flag, table width, row count
  always_ff @(posedge clk) begin
    if (rst) begin
      found      <= 1'b0;
      extent     <= '0;
      table_rows <= '0;
    end else begin
      if (cfg_write) begin
        table_rows <= cfg_data;
      end
      if (cmd.accept && s_tuser) begin
        extent <= '0;
      end else if (cmd.pick && (cand == '0)) begin
        extent <= COLS_FULL;
      end else if (cmd.mark && (run_end > extent)) begin
        extent <= run_end;
      end
      if (cmd.pick) begin
        found <= (cand != '0);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {3'b000, extent, found ? col : COL_LAST};
      m_tuser <= !found;
    end
  end

endmodule

FILE: rtl/tcgp_ctrl.sv
// Controller: sequences read, run search, pick, marking of covered rows and result hand-off.
module tcgp_ctrl import tcgp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  tcgp_stat_t stat,
  output tcgp_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_RUN    = 3'd2;
  localparam logic [2:0] ST_PICK   = 3'd3;
  localparam logic [2:0] ST_MARK   = 3'd4;
  localparam logic [2:0] ST_SREAD  = 3'd5;
  localparam logic [2:0] ST_SWRITE = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [BIT_W-1:0] bit_cnt;
  logic [BIT_W-1:0] bit_cnt_next;

  assign s_tready = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next   = state;
    bit_cnt_next = bit_cnt;
    cmd          = '0;
    cmd.bit_sel  = bit_cnt;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_own   = 1'b1;
        bit_cnt_next = SPAN_TOP_BIT;
        state_next   = ST_RUN;
      end
      ST_RUN: begin
        cmd.run_step = 1'b1;
        if (bit_cnt == '0) begin
          state_next = ST_PICK;
        end else begin
          bit_cnt_next = bit_cnt - BIT_W'(1);
        end
      end
      ST_PICK: begin
        cmd.pick   = 1'b1;
        state_next = ST_MARK;
      end
      ST_MARK: begin
        if (stat.found) begin
          cmd.mark   = 1'b1;
          state_next = ST_SREAD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SREAD: begin
        if (stat.span_more) begin
          cmd.rd_span = 1'b1;
          state_next  = ST_SWRITE;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SWRITE: begin
        cmd.wr_span = 1'b1;
        state_next  = ST_SREAD;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      bit_cnt <= '0;
    end else begin
      state   <= state_next;
      bit_cnt <= bit_cnt_next;
    end
  end

endmodule

FILE: rtl/tcgp_checker.sv
// Port-level checks for the cell placement grid, bound to the top level.
module tcgp_checker import tcgp_pkg::*; #(
  parameter int MAX_COLS = 64
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser
);

  localparam logic [EXT_W-1:0] COLS_FULL = EXT_W'(MAX_COLS);
  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(MAX_COLS - 1);

  // No result is shown right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // No transfer in the cycle after one
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a transfer");

  // Overflow saturates column and width
  a_overflow_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[5:0] == COL_LAST) && (m_tdata[12:6] == COLS_FULL))
    else $error("overflow result not saturated");

  // A placed cell lies inside the running width
  a_width_covers: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[12:6] > 7'(m_tdata[5:0])) &&
                             (m_tdata[12:6] <= COLS_FULL))
    else $error("placed column outside table width");

endmodule

bind table_cell_grid_placement tcgp_checker #(.MAX_COLS(MAX_COLS)) u_tcgp_checker (.*);
